// ===== hw/rtl/hcv_pkg.sv =====
`default_nettype none
package hcv_pkg;

    localparam int SHA_ROUNDS = 80;
    localparam int RND_W      = 7;
    localparam int TAG_W      = 20;

    typedef logic [159:0]      hash_t;
    typedef logic [15:0][31:0] win_t;   // index 0 is the oldest schedule word
    typedef logic [TAG_W-1:0]  tag_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } state_t;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_MID  = 2'd1,
        CFG_KEY_LOW  = 2'd2
    } cfg_idx_t;

    localparam hash_t SHA_H0 = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [7:0]  IPAD_BYTE  = 8'h36;
    localparam logic [7:0]  OPAD_BYTE  = 8'h5C;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] INNER_BITS = 32'd576;  // (64 + 8) bytes
    localparam logic [31:0] OUTER_BITS = 32'd672;  // (64 + 20) bytes

    // code = bin mod 1000000 = ((bin >> 6) mod 15625) << 6 | bin[5:0]
    localparam logic [24:0] MOD_DIV    = 25'd15625;
    localparam logic [23:0] MOD_RECIP  = 24'd8796093;  // floor(2^37 / 15625)
    localparam int          RECIP_SH   = 37;

    function automatic state_t hash_to_state(input hash_t h);
        state_t s;
        s = h;
        return s;
    endfunction

    function automatic hash_t hash_add(input hash_t h, input state_t s);
        hash_t r;
        r[159:128] = h[159:128] + s.a;
        r[127:96]  = h[127:96]  + s.b;
        r[95:64]   = h[95:64]   + s.c;
        r[63:32]   = h[63:32]   + s.d;
        r[31:0]    = h[31:0]    + s.e;
        return r;
    endfunction

    function automatic state_t sha1_round(input state_t s, input logic [31:0] w,
                                          input logic [RND_W-1:0] t);
        logic [31:0] f;
        logic [31:0] k;
        state_t      r;
        if (t < 7'd20) begin
            f = (s.b & s.c) | (~s.b & s.d);
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            f = s.b ^ s.c ^ s.d;
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
            k = 32'h8F1BBCDC;
        end else begin
            f = s.b ^ s.c ^ s.d;
            k = 32'hCA62C1D6;
        end
        r.a = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
        r.b = s.a;
        r.c = {s.b[1:0], s.b[31:2]};
        r.d = s.c;
        r.e = s.d;
        return r;
    endfunction

    function automatic win_t win_shift(input win_t w);
        logic [31:0] x;
        win_t        r;
        x = w[13] ^ w[8] ^ w[2] ^ w[0];
        r = {{x[30:0], x[31]}, w[15:1]};
        return r;
    endfunction

    function automatic win_t make_pad(input hash_t key, input logic [7:0] pb);
        win_t r;
        for (int j = 0; j < 16; j++) begin
            r[j] = {4{pb}};
        end
        for (int j = 0; j < 5; j++) begin
            r[j] = key[159-32*j -: 32] ^ {4{pb}};
        end
        return r;
    endfunction

    function automatic win_t make_inner(input logic [63:0] ctr);
        win_t r;
        r     = '0;
        r[0]  = ctr[63:32];
        r[1]  = ctr[31:0];
        r[2]  = PAD_WORD;
        r[15] = INNER_BITS;
        return r;
    endfunction

    function automatic win_t make_outer(input hash_t h);
        win_t r;
        r = '0;
        for (int j = 0; j < 5; j++) begin
            r[j] = h[159-32*j -: 32];
        end
        r[5]  = PAD_WORD;
        r[15] = OUTER_BITS;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hotp_code_verifier_unit.sv =====
// Channel   Handshake                  Payload
// request   start / busy               counter[63:0], candidate_code[19:0]
// result    result_valid (strobe)      code_matches, computed_code[19:0]
// config    cfg_valid / cfg_ready      cfg_index[1:0], cfg_data[63:0]
//
// One request per cycle while busy is low; each result passes through two 80-round SHA-1
// pipelines, their final adds and 4 truncation stages.
// After reset and after each key write, busy is high while one iterative
// round unit hashes the ipad and opad key blocks.
// The result side cannot stall; results stream out in request order.
`default_nettype none
module hotp_code_verifier_unit
    import hcv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] counter,
    input  wire logic [19:0] candidate_code,
    output logic             result_valid,
    output logic             code_matches,
    output logic [19:0]      computed_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_mid_reg;
    logic [31:0] key_low_reg;
    logic        restart_reg;

    logic        cfg_we;
    logic        pre_busy;
    hash_t       ih;
    hash_t       oh;
    logic        accept;

    logic        in_done;
    hash_t       in_digest;
    tag_t        in_tag;
    logic        out_done;
    hash_t       mac;
    tag_t        out_tag;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_MID
                                     || cfg_index == CFG_KEY_LOW);
    assign busy      = restart_reg | pre_busy;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_mid_reg  <= '0;
            key_low_reg  <= '0;
            restart_reg  <= 1'b1;
        end else begin
            restart_reg <= cfg_we;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_MID:  key_mid_reg  <= cfg_data;
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    hcv_key_pre u_key_pre (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (restart_reg),
        .key        ({key_high_reg, key_mid_reg, key_low_reg}),
        .busy       (pre_busy),
        .ipad_state (ih),
        .opad_state (oh)
    );

    hcv_sha1_pipe u_inner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .h_init    (ih),
        .block     (make_inner(counter)),
        .in_tag    (candidate_code),
        .out_valid (in_done),
        .digest    (in_digest),
        .out_tag   (in_tag)
    );

    hcv_sha1_pipe u_outer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_done),
        .h_init    (oh),
        .block     (make_outer(in_digest)),
        .in_tag    (in_tag),
        .out_valid (out_done),
        .digest    (mac),
        .out_tag   (out_tag)
    );

    hcv_trunc u_trunc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (out_done),
        .mac       (mac),
        .candidate (out_tag),
        .out_valid (result_valid),
        .hit       (code_matches),
        .code      (computed_code)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/hcv_key_pre.sv =====
`default_nettype none
module hcv_key_pre
    import hcv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire hash_t key,
    output logic       busy,
    output hash_t      ipad_state,
    output hash_t      opad_state
);

    logic             busy_reg;
    logic             phase_reg;
    logic [RND_W-1:0] cnt_reg;
    state_t           st_reg;
    win_t             win_reg;
    hash_t            ih_reg;
    hash_t            oh_reg;
    state_t           st_next;
    logic             last;

    assign st_next = sha1_round(st_reg, win_reg[0], cnt_reg);
    assign last    = (cnt_reg == RND_W'(SHA_ROUNDS - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (busy_reg) begin
            if (last) begin
                cnt_reg   <= '0;
                phase_reg <= 1'b1;
                if (phase_reg) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ipad block first, then opad block; both start from the standard IV
    always_ff @(posedge clk) begin
        if (start) begin
            st_reg  <= hash_to_state(SHA_H0);
            win_reg <= make_pad(key, IPAD_BYTE);
        end else if (busy_reg) begin
            if (last) begin
                st_reg  <= hash_to_state(SHA_H0);
                win_reg <= make_pad(key, OPAD_BYTE);
                if (phase_reg) begin
                    oh_reg <= hash_add(SHA_H0, st_next);
                end else begin
                    ih_reg <= hash_add(SHA_H0, st_next);
                end
            end else begin
                st_reg  <= st_next;
                win_reg <= win_shift(win_reg);
            end
        end
    end

    assign busy       = busy_reg;
    assign ipad_state = ih_reg;
    assign opad_state = oh_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hcv_sha1_pipe.sv =====
`default_nettype none
module hcv_sha1_pipe
    import hcv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire hash_t h_init,
    input  wire win_t  block,
    input  wire tag_t  in_tag,
    output logic       out_valid,
    output hash_t      digest,
    output tag_t       out_tag
);

    logic   valid_reg [SHA_ROUNDS];
    state_t st_reg    [SHA_ROUNDS];
    win_t   win_reg   [SHA_ROUNDS];
    tag_t   tag_reg   [SHA_ROUNDS];

    logic   fin_valid_reg;
    hash_t  fin_hash_reg;
    tag_t   fin_tag_reg;

    for (genvar i = 0; i < SHA_ROUNDS; i++) begin : g_round
        logic   v_in;
        state_t s_in;
        win_t   w_in;
        tag_t   t_in;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign s_in = hash_to_state(h_init);
            assign w_in = block;
            assign t_in = in_tag;
        end else begin : g_rest
            assign v_in = valid_reg[i-1];
            assign s_in = st_reg[i-1];
            assign w_in = win_reg[i-1];
            assign t_in = tag_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[i] <= 1'b0;
            end else begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            st_reg[i]  <= sha1_round(s_in, w_in[0], RND_W'(i));
            win_reg[i] <= win_shift(w_in);
            tag_reg[i] <= t_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fin_valid_reg <= 1'b0;
        end else begin
            fin_valid_reg <= valid_reg[SHA_ROUNDS-1];
        end
    end

    // h_init must change only while no request is in flight; the block does not enforce it
    always_ff @(posedge clk) begin
        fin_hash_reg <= hash_add(h_init, st_reg[SHA_ROUNDS-1]);
        fin_tag_reg  <= tag_reg[SHA_ROUNDS-1];
    end

    assign out_valid = fin_valid_reg;
    assign digest    = fin_hash_reg;
    assign out_tag   = fin_tag_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hcv_trunc.sv =====
`default_nettype none
module hcv_trunc
    import hcv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire hash_t mac,
    input  wire tag_t  candidate,
    output logic       out_valid,
    output logic       hit,
    output logic [19:0] code
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [30:0] s1_bin_reg;
    tag_t        s1_cand_reg, s2_cand_reg, s3_cand_reg;
    logic [24:0] s2_x_reg;
    logic [5:0]  s2_lo_reg, s3_lo_reg;
    logic [48:0] s2_prod_reg;
    logic [14:0] s3_rem_reg;
    logic        s4_match_reg;
    logic [19:0] s4_code_reg;

    logic [3:0]  off;
    logic [31:0] sel;
    logic [11:0] q_est;
    logic [13:0] rem_fix;
    logic [19:0] code_next;

    // byte at the offset lands in bits 31:24
    assign off   = mac[3:0];
    assign sel   = 32'(mac >> {5'd16 - {1'b0, off}, 3'b000});
    assign q_est = s2_prod_reg[48:RECIP_SH];
    assign rem_fix = (s3_rem_reg >= 15'(MOD_DIV)) ? 14'(s3_rem_reg - 15'(MOD_DIV))
                                                 : s3_rem_reg[13:0];
    assign code_next = {rem_fix, s3_lo_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_bin_reg  <= sel[30:0];
        s1_cand_reg <= candidate;

        s2_x_reg    <= s1_bin_reg[30:6];
        s2_lo_reg   <= s1_bin_reg[5:0];
        s2_prod_reg <= 49'(s1_bin_reg[30:6]) * 49'(MOD_RECIP);
        s2_cand_reg <= s1_cand_reg;

        // estimate is exact or one low, so the remainder stays below 2 * 15625
        s3_rem_reg  <= 15'(s2_x_reg - 25'(25'(q_est) * MOD_DIV));
        s3_lo_reg   <= s2_lo_reg;
        s3_cand_reg <= s2_cand_reg;

        s4_code_reg  <= code_next;
        s4_match_reg <= (code_next == s3_cand_reg);
    end

    assign out_valid = s4_valid_reg;
    assign hit       = s4_match_reg;
    assign code      = s4_code_reg;

endmodule
`default_nettype wire

// ===== tb/hotp_code_verifier_checker.sv =====
`default_nettype none
package hotp_tb_pkg;

    localparam logic [159:0] SHA1_INIT = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [31:0]  CODE_MOD  = 32'd1000000;

    typedef struct packed {
        logic        hit;
        logic [19:0] code;
    } otp_result_t;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                   input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = blk[511-32*i -: 32];
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // HMAC-SHA1 over the 8-byte counter, then dynamic truncation mod 10^6
    function automatic logic [19:0] hotp_value(input logic [159:0] key,
                                               input logic [63:0] ctr);
        logic [511:0] kblk;
        logic [159:0] inner;
        logic [159:0] mac;
        logic [31:0]  bin;
        int           off;
        kblk  = {key, 352'b0};
        inner = sha1_compress(sha1_compress(SHA1_INIT, kblk ^ {64{8'h36}}),
                              {ctr, 32'h8000_0000, 352'b0, 64'd576});
        mac   = sha1_compress(sha1_compress(SHA1_INIT, kblk ^ {64{8'h5C}}),
                              {inner, 32'h8000_0000, 256'b0, 64'd672});
        off   = mac[3:0];
        bin   = mac[159-8*off -: 32] & 32'h7FFF_FFFF;
        return 20'(bin % CODE_MOD);
    endfunction

endpackage

module hotp_code_verifier_checker
    import hcv_pkg::*;
    import hotp_tb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [63:0] counter,
    input  wire logic [19:0] candidate_code,
    input  wire logic        result_valid,
    input  wire logic        code_matches,
    input  wire logic [19:0] computed_code,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               outstanding,
    output int               fail_count
);

    logic [63:0] key_hi, key_mid;
    logic [31:0] key_lo;
    otp_result_t expected_codes [$];

    always @(posedge clk or negedge rst_n) begin
        otp_result_t got, want;
        logic [19:0] code;
        int          errs;
        errs = 0;
        if (!rst_n) begin
            key_hi      <= '0;
            key_mid     <= '0;
            key_lo      <= '0;
            outstanding <= 0;
            fail_count  <= 0;
            expected_codes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_KEY_HIGH: key_hi  <= cfg_data;
                    CFG_KEY_MID:  key_mid <= cfg_data;
                    CFG_KEY_LOW:  key_lo  <= cfg_data[31:0];
                    default: ;  // unmapped index is dropped
                endcase
            end
            if (result_valid) begin
                got = '{code_matches, computed_code};
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d",
                             $time, got.hit, got.code);
                    errs = errs + 1;
                end else begin
                    want = expected_codes.pop_front();
                    if (got.code !== want.code) begin
                        $display("%0t: computed_code expected %0d actual %0d",
                                 $time, want.code, got.code);
                        errs = errs + 1;
                    end
                    if (got.hit !== want.hit) begin
                        $display("%0t: code_matches expected %0d actual %0d",
                                 $time, want.hit, got.hit);
                        errs = errs + 1;
                    end
                end
            end
            if (start && !busy) begin
                code = hotp_value({key_hi, key_mid, key_lo}, counter);
                expected_codes.push_back('{candidate_code == code, code});
            end
            fail_count  <= fail_count + errs;
            outstanding <= expected_codes.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_hotp_code_verifier_unit.sv =====
`default_nettype none
module tb_hotp_code_verifier_unit;
    import hcv_pkg::*;
    import hotp_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] counter = '0;
    logic [19:0] candidate_code = '0;
    logic        result_valid;
    logic        code_matches;
    logic [19:0] computed_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          outstanding;
    int          fail_count;

    logic [159:0] cur_key = '0;
    bit           allow_gaps = 1'b1;

    always #10 clk = ~clk;

    hotp_code_verifier_unit DUT (.*);
    hotp_code_verifier_checker u_checker (.*);

    initial begin
        #(3_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        wait (outstanding == 0);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_HIGH: cur_key[159:96] = data;
            CFG_KEY_MID:  cur_key[95:32]  = data;
            CFG_KEY_LOW:  cur_key[31:0]   = data[31:0];
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [159:0] key, input logic [31:0] junk_hi);
        drain();
        write_reg(CFG_KEY_HIGH, key[159:96]);
        write_reg(CFG_KEY_MID, key[95:32]);
        write_reg(CFG_KEY_LOW, {junk_hi, key[31:0]});
    endtask

    task automatic send_request(input logic [63:0] ctr, input logic [19:0] cand);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        start          <= 1'b1;
        counter        <= ctr;
        candidate_code <= cand;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // candidate mix: exact hit, near miss, in-range random, full 20-bit noise
    task automatic random_request();
        logic [63:0] ctr;
        logic [19:0] good;
        ctr  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 50)) : rand64();
        good = hotp_value(cur_key, ctr);
        case ($urandom_range(0, 5))
            0, 1: send_request(ctr, good);
            2:    send_request(ctr, good ^ 20'(1 << $urandom_range(0, 19)));
            3, 4: send_request(ctr, 20'($urandom_range(0, 999999)));
            default: send_request(ctr, 20'($urandom));
        endcase
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            random_request();
        end
        start <= 1'b0;
    endtask

    initial begin
        logic [159:0] rfc_key;
        rfc_key = 160'h31323334353637383930_31323334353637383930;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key (all zero), field extremes
        send_request('0, '0);
        send_request('1, 20'd999999);
        send_request(64'h8000_0000_0000_0000, 20'hFFFFF);
        send_request(64'd1, 20'd1000000);
        send_request(64'd7, hotp_value(cur_key, 64'd7));
        start <= 1'b0;

        // published test key, counters 0..9, alternating hit and miss
        load_key(rfc_key, 32'h0);
        for (int i = 0; i < 10; i++) begin
            send_request(64'(i), hotp_value(cur_key, 64'(i)) ^ 20'(i % 2));
        end
        start <= 1'b0;

        // unmapped index must not disturb the key; key_low upper bits ignored
        drain();
        write_reg(cfg_idx_t'(2'd3), '1);
        send_request(64'd5, hotp_value(cur_key, 64'd5));
        start <= 1'b0;
        load_key('1, 32'hFFFF_FFFF);
        send_request('0, hotp_value(cur_key, '0));
        send_request('1, 20'hFFFFF);
        start <= 1'b0;

        random_phase(100);
        load_key('0, 32'hDEAD_BEEF);
        random_phase(80);
        for (int p = 0; p < 3; p++) begin
            load_key({rand64(), rand64(), $urandom}, $urandom);
            random_phase(100);
        end
        load_key(rfc_key, $urandom);
        allow_gaps = 1'b0;
        random_phase(100);

        wait (outstanding == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
